### design/rfg_pkg.sv
// Package for the radial falloff gradient pixel block.
// Shared widths and register indexes; depends on nothing.
package rfg_pkg;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 56;
  localparam logic [CFG_IDX_BITS-1:0] REG_ANCHOR0 = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FALLOFF0 = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_FALLOFF3 = 3'd7;
endpackage

### design/rfg_cell.sv
// One stage of the root pipeline: settles one bit of the integer square root.
// Depends on nothing; chained by rfg_sqrt.
module rfg_cell #(
  parameter int unsigned VW = 50,
  parameter int unsigned RW = 25,
  parameter int unsigned BIT = 0
) (
  input  logic          clk,
  input  logic [VW-1:0] rem_in,
  input  logic [RW-1:0] root_in,
  output logic [VW-1:0] rem_out,
  output logic [RW-1:0] root_out
);
  logic [VW-1:0] trial;
  logic [VW-1:0] rt_ext;
  always_comb begin
    rt_ext = VW'(root_in);
    trial = (rt_ext << (BIT + 1)) | (VW'(1) << (2 * BIT));
  end
  always_ff @(posedge clk) begin
    if (rem_in >= trial) begin
      rem_out <= rem_in - trial;
      root_out <= root_in | (RW'(1) << BIT);
    end else begin
      rem_out <= rem_in;
      root_out <= root_in;
    end
  end
endmodule

### design/rfg_sqrt.sv
// Chain of rfg_cell stages computing floor(sqrt(value)), one bit per stage.
// Depends on rfg_cell.
module rfg_sqrt #(
  parameter int unsigned VW = 50,
  parameter int unsigned RW = 25
) (
  input  logic          clk,
  input  logic [VW-1:0] value,
  output logic [RW-1:0] root
);
  logic [VW-1:0] rem [RW+1];
  logic [RW-1:0] rt [RW+1];
  assign rem[0] = value;
  assign rt[0] = '0;
  for (genvar g = 0; g < RW; g++) begin : g_cell
    rfg_cell #(.VW(VW), .RW(RW), .BIT(RW - 1 - g)) u_cell (
      .clk(clk), .rem_in(rem[g]), .root_in(rt[g]),
      .rem_out(rem[g+1]), .root_out(rt[g+1]));
  end
  assign root = rt[RW];
endmodule

### design/rfg_div.sv
// Pipelined restoring divider, one quotient bit per stage, for colour*(R-d)/R.
// Depends on nothing.
module rfg_div #(
  parameter int unsigned NW = 40,
  parameter int unsigned DW = 32
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);
  logic [NW-1:0] q [NW+1];
  logic [DW:0]   r [NW+1];
  logic [NW-1:0] n [NW+1];
  logic [DW-1:0] d [NW+1];
  assign q[0] = '0;
  assign r[0] = '0;
  assign n[0] = num;
  assign d[0] = den;
  for (genvar g = 0; g < NW; g++) begin : g_st
    logic [DW:0] sh;
    assign sh = {r[g][DW-1:0], n[g][NW-1-g]};
    always_ff @(posedge clk) begin
      n[g+1] <= n[g];
      d[g+1] <= d[g];
      if (sh >= {1'b0, d[g]}) begin
        r[g+1] <= sh - {1'b0, d[g]};
        q[g+1] <= q[g] | (NW'(1) << (NW - 1 - g));
      end else begin
        r[g+1] <= sh;
        q[g+1] <= q[g];
      end
    end
  end
  assign quo = q[NW];
endmodule

### design/radial_falloff_gradient_pixel.sv
// Top level of the radial falloff gradient pixel block.
// Depends on rfg_pkg, rfg_sqrt and rfg_div.
//
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------
// pixel    | start / busy         | pixel_x, pixel_y
// config   | cfg_valid / cfg_ready| cfg_index, cfg_data
// result   | done (one cycle)     | red_out, green_out, blue_out
//
// One item is accepted every clock; busy is always low. Each result comes
// out with done after the square root chain (one cell per root bit), the
// divider chain (one stage per quotient bit) and four register stages
// around them. Reset clears the valid pipe and the anchor registers and
// sets every falloff register to 1. The receiver cannot stall, so nothing
// ever holds back.
module radial_falloff_gradient_pixel #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned NUM_ANCHORS = 4,
  parameter int unsigned DIST_FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [15:0]                   pixel_x,
  input  logic [15:0]                   pixel_y,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rfg_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [rfg_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output logic                          done,
  output logic [7:0]                    red_out,
  output logic [7:0]                    green_out,
  output logic [7:0]                    blue_out
);
  import rfg_pkg::*;

  // The squared distance carries 2*DIST_FRAC_BITS fraction bits.
  localparam int unsigned SQW = 2 * COORD_BITS + 1 + 2 * DIST_FRAC_BITS;
  localparam int unsigned VW = SQW + (SQW % 2);
  localparam int unsigned RW = VW / 2;
  localparam int unsigned DW = 16 + DIST_FRAC_BITS;
  localparam int unsigned NW = DW + 8;
  localparam int unsigned LAT = 2 + RW + 1 + NW + 1;

  logic [55:0] anchor [4];
  logic [15:0] falloff [4];

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration writes; indexes above the list fall through.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        anchor[i] <= '0;
        falloff[i] <= 16'd1;
      end
    end else if (cfg_valid) begin
      if (cfg_index < REG_FALLOFF0) begin
        anchor[cfg_index[1:0]] <= cfg_data;
      end else if (cfg_index <= REG_FALLOFF3) begin
        falloff[cfg_index[1:0]] <= cfg_data[15:0];
      end
    end
  end

  // Valid pipe covering the whole latency.
  logic [LAT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[LAT-2:0], start};
  end
  assign done = vld[LAT-1];

  // Stage 1: absolute differences and exact-hit detection.
  logic [COORD_BITS-1:0] px, py;
  assign px = pixel_x[COORD_BITS-1:0];
  assign py = pixel_y[COORD_BITS-1:0];

  logic [COORD_BITS-1:0] dx [4];
  logic [COORD_BITS-1:0] dy [4];
  logic [3:0] hit1;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      logic [COORD_BITS-1:0] ax, ay;
      ax = anchor[i][40 +: COORD_BITS];
      ay = anchor[i][24 +: COORD_BITS];
      dx[i] <= (px > ax) ? px - ax : ax - px;
      dy[i] <= (py > ay) ? py - ay : ay - py;
      hit1[i] <= (ax == px) && (ay == py) && (i < NUM_ANCHORS);
    end
  end

  // Hit colour: first matching anchor, carried along with the item.
  logic [23:0] hcol1;
  logic hany1;
  always_comb begin
    hcol1 = '0;
    hany1 = 1'b0;
    for (int i = 3; i >= 0; i--) begin
      if (hit1[i]) begin
        hcol1 = anchor[i][23:0];
        hany1 = 1'b1;
      end
    end
  end
  logic [24:0] hpipe [LAT-2];
  always_ff @(posedge clk) begin
    hpipe[0] <= {hany1, hcol1};
    for (int k = 1; k < LAT - 2; k++) hpipe[k] <= hpipe[k-1];
  end

  logic [23:0] term [4];
  for (genvar a = 0; a < 4; a++) begin : g_anc
    // Stage 2: squared distance.
    logic [2*COORD_BITS-1:0] dxsq, dysq;
    assign dxsq = (2*COORD_BITS)'(dx[a]) * (2*COORD_BITS)'(dx[a]);
    assign dysq = (2*COORD_BITS)'(dy[a]) * (2*COORD_BITS)'(dy[a]);
    logic [VW-1:0] sq;
    always_ff @(posedge clk) begin
      sq <= VW'({1'b0, dxsq} + {1'b0, dysq}) << (2 * DIST_FRAC_BITS);
    end
    logic [RW-1:0] dist_fx;
    rfg_sqrt #(.VW(VW), .RW(RW)) u_sqrt (.clk(clk), .value(sq), .root(dist_fx));

    // Stage after root: colour*(R-d) per channel, registered.
    logic [DW-1:0] rad;
    assign rad = DW'(falloff[a]) << DIST_FRAC_BITS;
    logic [NW-1:0] num [3];
    logic [DW-1:0] den;
    logic live;
    always_ff @(posedge clk) begin
      live <= (RW'(dist_fx) < RW'(rad)) && (a < NUM_ANCHORS);
      den <= rad;
      for (int c = 0; c < 3; c++)
        num[c] <= NW'(anchor[a][8*(2-c) +: 8]) * NW'(DW'(rad - DW'(dist_fx)));
    end
    logic [NW-1:0] livep;
    always_ff @(posedge clk) livep <= {livep[NW-2:0], live};
    for (genvar c = 0; c < 3; c++) begin : g_ch
      logic [NW-1:0] q;
      rfg_div #(.NW(NW), .DW(DW)) u_div (.clk(clk), .num(num[c]), .den(den), .quo(q));
      assign term[a][8*(2-c) +: 8] = livep[NW-1] ? q[7:0] : 8'd0;
    end
  end

  // Final stage: saturating sum, or the hit colour.
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      logic [9:0] s;
      logic [7:0] v;
      s = 10'(term[0][8*c +: 8]) + 10'(term[1][8*c +: 8])
        + 10'(term[2][8*c +: 8]) + 10'(term[3][8*c +: 8]);
      v = (s > 10'd255) ? 8'd255 : s[7:0];
      if (hpipe[LAT-3][24]) v = hpipe[LAT-3][8*c +: 8];
      if (c == 2) red_out <= v;
      if (c == 1) green_out <= v;
      if (c == 0) blue_out <= v;
    end
  end
endmodule

### design/rfg_checker.sv
// Port-level checks for radial_falloff_gradient_pixel, with its bind.
// Depends on the top level's ports only.
module rfg_checker (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic cfg_ready,
  input logic done
);
  a_busy: assert property (@(posedge clk) disable iff (rst) !busy) else $error("busy");
  a_cfg: assert property (@(posedge clk) disable iff (rst) cfg_ready) else $error("cfg");
  a_rst: assert property (@(posedge clk) $past(rst) |-> !done) else $error("done after reset");
endmodule

bind radial_falloff_gradient_pixel rfg_checker u_chk (
  .clk(clk), .rst(rst), .busy(busy), .cfg_ready(cfg_ready), .done(done));

### test/tb_radial_falloff_gradient_pixel.sv
// Testbench for the radial falloff gradient pixel block.
// Drives pixels, anchor and falloff register writes and checks every colour
// against an in-bench predictor. Depends on rfg_pkg and the block itself.
`timescale 1ns / 1ps

module tb_radial_falloff_gradient_pixel;
  import rfg_pkg::*;

  // Settle time before a register write. It is well beyond the square root
  // chain, the divider chain and the register stages of the block.
  localparam int SETTLE_CYCLES = 200;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [55:0] ANCHOR_ONES = {56{1'b1}};

  typedef enum logic [1:0] {OP_PIXEL, OP_WRITE, OP_DRAIN} op_kind_t;

  typedef struct {
    op_kind_t kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [CFG_IDX_BITS-1:0] idx;
    logic [CFG_DATA_BITS-1:0] data;
  } op_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [15:0] pixel_x = '0;
  logic [15:0] pixel_y = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic done;
  logic [7:0] red_out, green_out, blue_out;

  radial_falloff_gradient_pixel dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pixel_x(pixel_x), .pixel_y(pixel_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .red_out(red_out), .green_out(green_out), .blue_out(blue_out)
  );

  always #5 clk = ~clk;

  // Pending operations from the stimulus block, and colours still owed by
  // the block in the order their pixels went in.
  op_t pending_ops[$];
  color_t colors_owed[$];
  int mismatches = 0;
  int cycle_count = 0;
  int pixels_sent = 0;
  int settle_left = 0;

  // Shadow copy of the block's registers, updated when a write is accepted.
  logic [55:0] anchor_reg[4];
  logic [15:0] falloff_reg[4];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  // Exact integer square root, one result bit per pass from the top down.
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic color_t falloff_color(input logic [15:0] px, input logic [15:0] py);
    color_t res;
    longint unsigned sum[3];
    longint unsigned ax, ay, dx, dy, root_dist, rad;
    longint unsigned col[3];
    sum[0] = 0; sum[1] = 0; sum[2] = 0;
    for (int i = 0; i < 4; i++) begin
      ax = anchor_reg[i][55:40];
      ay = anchor_reg[i][39:24];
      col[0] = anchor_reg[i][23:16];
      col[1] = anchor_reg[i][15:8];
      col[2] = anchor_reg[i][7:0];
      // An exact hit returns the first such anchor's colour untouched.
      if (ax == px && ay == py) begin
        res.red = 8'(col[0]); res.green = 8'(col[1]); res.blue = 8'(col[2]);
        return res;
      end
      dx = (px > ax) ? px - ax : ax - px;
      dy = (py > ay) ? py - ay : ay - py;
      root_dist = floor_sqrt((dx * dx + dy * dy) << 16);
      rad = longint'(falloff_reg[i]) << 8;
      if (root_dist < rad)
        for (int c = 0; c < 3; c++) sum[c] += col[c] * (rad - root_dist) / rad;
    end
    res.red = (sum[0] > 255) ? 8'd255 : sum[0][7:0];
    res.green = (sum[1] > 255) ? 8'd255 : sum[1][7:0];
    res.blue = (sum[2] > 255) ? 8'd255 : sum[2][7:0];
    return res;
  endfunction

  // Driver. Handshakes are sampled at the edge, and outside reset each input gets
  // one nonblocking assignment per edge from the values worked out here.
  always @(posedge clk) begin
    logic n_start, n_cvalid;
    logic [15:0] n_x, n_y;
    logic [CFG_IDX_BITS-1:0] n_idx;
    logic [CFG_DATA_BITS-1:0] n_data;
    bit quiet;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        anchor_reg[i] = '0;
        falloff_reg[i] = 16'd1;
      end
    end else begin
      cycle_count++;
      n_start = start; n_cvalid = cfg_valid;
      n_x = pixel_x; n_y = pixel_y; n_idx = cfg_index; n_data = cfg_data;
      if (start && !busy) begin
        colors_owed = {colors_owed, falloff_color(pixel_x, pixel_y)};
        n_start = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index >= REG_FALLOFF0)
          falloff_reg[2'(cfg_index - REG_FALLOFF0)] = cfg_data[15:0];
        else
          anchor_reg[2'(cfg_index - REG_ANCHOR0)] = cfg_data[55:0];
        n_cvalid = 1'b0;
      end
      if (!n_start && !n_cvalid) begin
        // A long window in the middle of the run adds no random idle cycles between pixels.
        quiet = (pixels_sent >= 700 && pixels_sent < 1000);
        if (settle_left > 0) begin
          settle_left--;
        end else if (pending_ops.size() > 0) begin
          case (pending_ops[0].kind)
            OP_PIXEL: begin
              if (quiet || $urandom_range(99) >= 29) begin
                n_start = 1'b1;
                n_x = pending_ops[0].x;
                n_y = pending_ops[0].y;
                pixels_sent++;
                void'(pending_ops.pop_front());
              end
            end
            OP_WRITE: begin
              if ($urandom_range(99) >= 29) begin
                n_cvalid = 1'b1;
                n_idx = pending_ops[0].idx;
                n_data = pending_ops[0].data;
                void'(pending_ops.pop_front());
              end
            end
            default: begin
              // Hold off until every owed colour has come, then settle.
              if (colors_owed.size() == 0) begin
                settle_left = SETTLE_CYCLES;
                void'(pending_ops.pop_front());
              end
            end
          endcase
        end
      end
      start <= n_start; cfg_valid <= n_cvalid;
      pixel_x <= n_x; pixel_y <= n_y; cfg_index <= n_idx; cfg_data <= n_data;
    end
  end

  // Monitor. Each done cycle carries one colour, checked against the oldest.
  always @(posedge clk) begin
    color_t want;
    if (!rst && done) begin
      if (colors_owed.size() == 0) begin
        report_mismatch("unexpected item, red", red_out, 0);
      end else begin
        want = colors_owed.pop_front();
        if (red_out !== want.red) report_mismatch("red", red_out, want.red);
        if (green_out !== want.green) report_mismatch("green", green_out, want.green);
        if (blue_out !== want.blue) report_mismatch("blue", blue_out, want.blue);
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  task automatic add_pixel(input logic [15:0] x, input logic [15:0] y);
    op_t o;
    o.kind = OP_PIXEL; o.x = x; o.y = y; o.idx = '0; o.data = '0;
    pending_ops = {pending_ops, o};
  endtask

  task automatic add_drain();
    op_t o;
    o.kind = OP_DRAIN; o.x = '0; o.y = '0; o.idx = '0; o.data = '0;
    pending_ops = {pending_ops, o};
  endtask

  // A write always waits for the block to go idle first.
  task automatic add_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [55:0] data);
    op_t o;
    add_drain();
    o.kind = OP_WRITE; o.x = '0; o.y = '0; o.idx = idx; o.data = data;
    pending_ops = {pending_ops, o};
  endtask

  function automatic logic [55:0] pack_anchor(input logic [15:0] x, input logic [15:0] y,
                                              input logic [23:0] rgb);
    return {x, y, rgb};
  endfunction

  logic [15:0] ax_plan[4];
  logic [15:0] ay_plan[4];

  initial begin
    logic [15:0] base_x, base_y, spread, px, py;
    int mode, pick, k;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part. With reset registers every anchor sits at the origin.
    add_pixel(16'd0, 16'd0);
    add_pixel(16'd1, 16'd0);
    add_pixel(16'hFFFF, 16'hFFFF);

    // Anchors 1 and 2 share a spot, so the lower one must win on a hit.
    add_write(CFG_IDX_BITS'(REG_ANCHOR0 + 0), pack_anchor(16'd100, 16'd100, 24'hFF8000));
    add_write(CFG_IDX_BITS'(REG_ANCHOR0 + 1), pack_anchor(16'd110, 16'd100, 24'h00FF40));
    add_write(CFG_IDX_BITS'(REG_ANCHOR0 + 2), pack_anchor(16'd110, 16'd100, 24'h123456));
    add_write(CFG_IDX_BITS'(REG_ANCHOR0 + 3), ANCHOR_ONES);
    add_write(CFG_IDX_BITS'(REG_FALLOFF0 + 0), 56'd20);
    add_write(CFG_IDX_BITS'(REG_FALLOFF0 + 1), 56'd65535);
    add_write(CFG_IDX_BITS'(REG_FALLOFF0 + 2), 56'd0);
    add_write(CFG_IDX_BITS'(REG_FALLOFF0 + 3), 56'd1);
    add_pixel(16'd100, 16'd100);
    add_pixel(16'd110, 16'd100);
    add_pixel(16'hFFFF, 16'hFFFF);
    add_pixel(16'hFFFE, 16'hFFFF);
    add_pixel(16'd105, 16'd100);
    add_pixel(16'd100, 16'd119);
    add_pixel(16'd100, 16'd120);
    add_pixel(16'd0, 16'd0);
    add_pixel(16'd0, 16'hFFFF);
    add_pixel(16'hFFFF, 16'd0);
    add_pixel(16'h5555, 16'hAAAA);

    // Saturation: all bright anchors close together with wide radii.
    for (int i = 0; i < 4; i++) begin
      add_write(CFG_IDX_BITS'(REG_ANCHOR0 + i),
                pack_anchor(16'(1000 + i), 16'd1000, 24'hFFFFFF));
      add_write(CFG_IDX_BITS'(REG_FALLOFF0 + i), 56'd65535);
    end
    add_pixel(16'd1001, 16'd1001);
    add_pixel(16'd1500, 16'd900);
    add_pixel(16'd1003, 16'd1000);

    // Random phases, each with a fresh register set in one of four flavors taken in turn.
    for (int ph = 0; ph < 12; ph++) begin
      mode = ph % 4;
      base_x = 16'($urandom);
      base_y = 16'($urandom);
      spread = (mode == 1) ? 16'hFFFF : 16'd60;
      for (int i = 0; i < 4; i++) begin
        ax_plan[i] = (mode == 1) ? 16'($urandom) : base_x + 16'($urandom_range(spread));
        ay_plan[i] = (mode == 1) ? 16'($urandom) : base_y + 16'($urandom_range(spread));
        add_write(CFG_IDX_BITS'(REG_ANCHOR0 + i),
                  pack_anchor(ax_plan[i], ay_plan[i],
                              (mode == 2) ? 24'hFFFFFF : 24'($urandom)));
        case (mode)
          1: add_write(CFG_IDX_BITS'(REG_FALLOFF0 + i), 56'($urandom_range(65535)));
          2: add_write(CFG_IDX_BITS'(REG_FALLOFF0 + i),
                       56'd65535 - 56'($urandom_range(3)));
          3: add_write(CFG_IDX_BITS'(REG_FALLOFF0 + i), 56'($urandom_range(2)));
          default: add_write(CFG_IDX_BITS'(REG_FALLOFF0 + i), 56'($urandom_range(1, 100)));
        endcase
      end
      for (int n = 0; n < 150; n++) begin
        pick = $urandom_range(99);
        k = $urandom_range(3);
        if (pick < 20) begin
          px = ax_plan[k]; py = ay_plan[k];
        end else if (pick < 80) begin
          px = ax_plan[k] + 16'($urandom_range(240)) - 16'd120;
          py = ay_plan[k] + 16'($urandom_range(240)) - 16'd120;
        end else begin
          px = 16'($urandom); py = 16'($urandom);
        end
        add_pixel(px, py);
        if (n == 75 && ph == 5) add_drain();
      end
    end
    add_drain();

    wait (pending_ops.size() == 0 && settle_left == 0 && !start && colors_owed.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && colors_owed.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
